// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check, off while reset is held.
`define PTW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Next-cycle check: cons must hold in the cycle after ante.
`define PTW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ptw_pkg.sv
package ptw_pkg;

    // Input item kinds
    localparam logic KIND_XLATE = 1'b0;
    localparam logic KIND_RESP  = 1'b1;

    // Result item kinds
    localparam logic RES_READ = 1'b0;
    localparam logic RES_DONE = 1'b1;

    // Register indexes on the config port
    localparam logic REG_ROOT   = 1'b0;
    localparam logic REG_WINDOW = 1'b1;

    localparam int ADDR_W      = 64;
    localparam int VA_W        = 48;
    localparam int PA_W        = 52;
    localparam int FIELD_W     = 40;   // entry bits 51..12
    localparam int IDX_W       = 9;
    localparam int PG_OFF_W    = 12;
    localparam logic [1:0] LAST_LEVEL = 2'd3;
    localparam int PRESENT_BIT = 0;

    // Job queue sizing
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic              kind;
        logic [VA_W-1:0]   vaddr;
        logic [ADDR_W-1:0] table_entry;
    } t_in_item;

    typedef struct packed {
        logic              kind_res;
        logic [ADDR_W-1:0] read_addr;
        logic [PA_W-1:0]   phys_addr;
        logic              fault;
        logic [1:0]        fault_level;
    } t_out_item;

    // Work the back end carries out for one accepted item
    typedef enum logic [1:0] {
        OP_ROOT,    // read top-level entry
        OP_NEXT,    // read next-level entry
        OP_FAULT,   // finish with fault
        OP_DONE     // finish with physical address
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [1:0]          level;
        logic [FIELD_W-1:0]  field;
        logic [IDX_W-1:0]    idx;
        logic [PG_OFF_W-1:0] pg_off;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // 9-bit table index for a level, top level first
    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        unique case (lvl)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

// File: sv/ptw_front.sv
module ptw_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ptw_pkg::t_in_item i_item,
    input  ptw_pkg::t_q_stat  i_q_stat,
    output logic              o_ready,
    output logic              o_push,
    output ptw_pkg::t_job     o_job
);

    logic                         r_active;
    logic [1:0]                   r_level;
    logic [ptw_pkg::VA_W-1:0]     r_saved_virt;
    logic                         n_active;
    logic [1:0]                   n_level;
    logic [ptw_pkg::VA_W-1:0]     n_saved_virt;
    logic                         accept;
    logic [1:0]                   next_level;

    assign o_ready    = !i_q_stat.full;
    assign accept     = i_valid && o_ready;
    assign next_level = r_level + 2'd1;

    // Classify the item against the walk state
    always_comb begin
        n_active     = r_active;
        n_level      = r_level;
        n_saved_virt = r_saved_virt;
        o_push       = 1'b0;
        o_job.op     = ptw_pkg::OP_ROOT;
        o_job.level  = r_level;
        o_job.field  = i_item.table_entry[51:12];
        o_job.idx    = ptw_pkg::level_index(i_item.vaddr, 2'd0);
        o_job.pg_off = r_saved_virt[ptw_pkg::PG_OFF_W-1:0];
        if (accept) begin
            if (i_item.kind == ptw_pkg::KIND_XLATE) begin
                // new walk only when idle; otherwise dropped
                if (!r_active) begin
                    n_active     = 1'b1;
                    n_level      = 2'd0;
                    n_saved_virt = i_item.vaddr;
                    o_push       = 1'b1;
                end
            end else if (r_active) begin
                o_push = 1'b1;
                if (!i_item.table_entry[ptw_pkg::PRESENT_BIT]) begin
                    o_job.op = ptw_pkg::OP_FAULT;
                    n_active = 1'b0;
                    n_level  = 2'd0;
                end else if (r_level != ptw_pkg::LAST_LEVEL) begin
                    o_job.op  = ptw_pkg::OP_NEXT;
                    o_job.idx = ptw_pkg::level_index(r_saved_virt, next_level);
                    n_level   = next_level;
                end else begin
                    o_job.op = ptw_pkg::OP_DONE;
                    n_active = 1'b0;
                    n_level  = 2'd0;
                end
            end
        end
    end

    // Walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_level      <= 2'd0;
            r_saved_virt <= '0;
        end else begin
            r_active     <= n_active;
            r_level      <= n_level;
            r_saved_virt <= n_saved_virt;
        end
    end

endmodule

// File: sv/ptw_job_queue.sv
module ptw_job_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ptw_pkg::t_job    i_job,
    input  logic             i_pop,
    output ptw_pkg::t_job    o_job,
    output ptw_pkg::t_q_stat o_stat
);

    ptw_pkg::t_job                r_mem [ptw_pkg::Q_DEPTH];
    logic [ptw_pkg::Q_PTR_W-1:0]  r_wr_ptr;
    logic [ptw_pkg::Q_PTR_W-1:0]  r_rd_ptr;
    logic [ptw_pkg::Q_CNT_W-1:0]  r_count;

    function automatic logic [ptw_pkg::Q_PTR_W-1:0] ptr_inc(
        input logic [ptw_pkg::Q_PTR_W-1:0] ptr);
        logic [ptw_pkg::Q_PTR_W-1:0] nxt;
        if (ptr == ptw_pkg::Q_PTR_W'(ptw_pkg::Q_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = ptr + ptw_pkg::Q_PTR_W'(1);
        end
        return nxt;
    endfunction

    assign o_stat.full  = (r_count == ptw_pkg::Q_CNT_W'(ptw_pkg::Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_job        = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + ptw_pkg::Q_CNT_W'(1);
                2'b01:   r_count <= r_count - ptw_pkg::Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: sv/ptw_back.sv
module ptw_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ptw_pkg::t_job               i_job,
    input  ptw_pkg::t_q_stat            i_q_stat,
    input  logic [ptw_pkg::ADDR_W-1:0]  i_root_addr,
    input  logic [ptw_pkg::ADDR_W-1:0]  i_window,
    input  logic                        i_ready,
    output logic                        o_pop,
    output logic                        o_valid,
    output ptw_pkg::t_out_item          o_item
);

    logic                        r_valid;
    ptw_pkg::t_out_item          r_item;
    ptw_pkg::t_out_item          n_item;
    logic [ptw_pkg::ADDR_W-1:0]  idx_off;
    logic [ptw_pkg::ADDR_W-1:0]  table_base;

    // Take a job whenever the output slot is free or being drained
    assign o_pop = !i_q_stat.empty && (!r_valid || i_ready);

    assign idx_off    = {{(ptw_pkg::ADDR_W - ptw_pkg::IDX_W - 3){1'b0}}, i_job.idx, 3'b000};
    assign table_base = {{(ptw_pkg::ADDR_W - ptw_pkg::FIELD_W - 12){1'b0}},
                         i_job.field, 12'h000};

    // Build the result item
    always_comb begin
        n_item.kind_res    = ptw_pkg::RES_READ;
        n_item.read_addr   = '0;
        n_item.phys_addr   = '0;
        n_item.fault       = 1'b0;
        n_item.fault_level = 2'd0;
        unique case (i_job.op)
            ptw_pkg::OP_ROOT: begin
                n_item.read_addr = i_root_addr + idx_off;
            end
            ptw_pkg::OP_NEXT: begin
                n_item.read_addr = table_base + i_window + idx_off;
            end
            ptw_pkg::OP_FAULT: begin
                n_item.kind_res    = ptw_pkg::RES_DONE;
                n_item.fault       = 1'b1;
                n_item.fault_level = i_job.level;
            end
            default: begin
                n_item.kind_res  = ptw_pkg::RES_DONE;
                n_item.phys_addr = {i_job.field, i_job.pg_off};
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: sv/page_table_walk_translate.sv
// Four-level page-table walker, one translation in flight.
// Input channel (i_valid/o_ready, i_item): a translate request (kind 0) starts
// a walk and yields a read of the top-level entry; a table entry response
// (kind 1) yields the next read, or the finished translation or fault.
// A request during a walk or a response while idle is taken and dropped.
// Output channel (o_valid/i_ready, o_item): read requests and finished results.
// Config: APB-style port, root table address at 0x0, window offset at 0x8,
// both 64 bits; write only while no walk is in flight.
// A result is valid once its item has passed the job queue and the output register (the item
// is classified into the job queue when accepted, the address add lands in the output register
// when the job is popped). Throughput: one item per cycle while the receiver does not stall,
// set by the single add stage.
// When the receiver stalls, the output register holds and the two-entry job
// queue takes further items; o_ready drops once the queue is full.
// Reset clears the walk state, the queue, the output valid and both registers.
`include "assert_macros.svh"

module page_table_walk_translate (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  ptw_pkg::t_in_item          i_item,
    output logic                       o_valid,
    input  logic                       i_ready,
    output ptw_pkg::t_out_item         o_item,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [3:0]                 paddr,
    input  logic [ptw_pkg::ADDR_W-1:0] pwdata,
    output logic [ptw_pkg::ADDR_W-1:0] prdata,
    output logic                       pready
);

    logic [ptw_pkg::ADDR_W-1:0] r_root_addr;
    logic [ptw_pkg::ADDR_W-1:0] r_window;
    logic                       cfg_wr;
    logic                       q_push;
    logic                       q_pop;
    ptw_pkg::t_job              push_job;
    ptw_pkg::t_job              head_job;
    ptw_pkg::t_q_stat           q_stat;

    // Config registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[3] == ptw_pkg::REG_WINDOW) ? r_window : r_root_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_addr <= '0;
            r_window    <= '0;
        end else if (cfg_wr) begin
            if (paddr[3] == ptw_pkg::REG_ROOT) begin
                r_root_addr <= pwdata;
            end else begin
                r_window <= pwdata;
            end
        end
    end

    ptw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_item   (i_item),
        .i_q_stat (q_stat),
        .o_ready  (o_ready),
        .o_push   (q_push),
        .o_job    (push_job)
    );

    ptw_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    ptw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_q_stat    (q_stat),
        .i_root_addr (r_root_addr),
        .i_window    (r_window),
        .i_ready     (i_ready),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .o_item      (o_item)
    );

    // Checks
    `PTW_ASSERT(a_q_no_overflow, i_clk, i_rst_n, q_push |-> !q_stat.full, "job pushed into full queue")
    `PTW_ASSERT(a_q_no_underflow, i_clk, i_rst_n, q_pop |-> !q_stat.empty, "job popped from empty queue")
    `PTW_ASSERT_NEXT(a_pop_shows, i_clk, i_rst_n, q_pop, o_valid, "popped job not presented")
    `PTW_ASSERT(a_read_clean, i_clk, i_rst_n, (o_valid && o_item.kind_res == ptw_pkg::RES_READ) |-> (!o_item.fault && o_item.phys_addr == '0 && o_item.fault_level == 2'd0), "read request carries result fields")

endmodule

// File: verif/tb.sv
module tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_ITEMS   = 125;
    localparam logic [63:0] ADDR_FIELD_MASK = 64'h000F_FFFF_FFFF_F000;

    // How a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,  // expectation from the walk predictor
        CHK_NONE,   // item must be dropped, no result
        CHK_FIXED   // expectation typed into the row
    } t_stim_check;

    typedef struct packed {
        ptw_pkg::t_in_item  item;
        t_stim_check        chk;
        ptw_pkg::t_out_item res;
    } t_stim_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_ready;
    ptw_pkg::t_in_item           i_item;
    logic                        o_valid;
    logic                        i_ready;
    ptw_pkg::t_out_item          o_item;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [3:0]                  paddr;
    logic [ptw_pkg::ADDR_W-1:0]  pwdata;
    logic [ptw_pkg::ADDR_W-1:0]  prdata;
    logic                        pready;

    // Walker shadow state and register copies
    logic                        walk_busy;
    logic [1:0]                  walk_lvl;
    logic [ptw_pkg::VA_W-1:0]    walk_va;
    logic [ptw_pkg::ADDR_W-1:0]  cfg_root;
    logic [ptw_pkg::ADDR_W-1:0]  cfg_window;

    ptw_pkg::t_out_item  pending_results[$];
    t_stim_row           dir_rows[$];

    int  errors;
    int  cycle_cnt;
    int  items_taken;
    int  n_reads;
    int  n_done;
    int  n_faults;
    int  n_settings;
    bit  src_burst;
    bit  sink_burst;
    bit  hold_req;

    page_table_walk_translate uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run-away guard
    always @(posedge i_clk) begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic note_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR: %s", msg);
    endtask

    // Byte offset of the entry for a level within its table
    function automatic logic [63:0] entry_offset(input logic [ptw_pkg::VA_W-1:0] va,
                                                 input logic [1:0] lvl);
        logic [ptw_pkg::VA_W-1:0] sh;
        sh = va >> (39 - 9 * int'(lvl));
        return {52'd0, sh[8:0], 3'b000};
    endfunction

    // Advance the walk by one item; returns 1 when a result is due
    function automatic bit walk_predict(input ptw_pkg::t_in_item it,
                                        output ptw_pkg::t_out_item res);
        logic [63:0] field;
        res = '0;
        if (it.kind == ptw_pkg::KIND_XLATE) begin
            if (walk_busy)
                return 1'b0;
            walk_busy     = 1'b1;
            walk_lvl      = 2'd0;
            walk_va       = it.vaddr;
            res.kind_res  = ptw_pkg::RES_READ;
            res.read_addr = cfg_root + entry_offset(it.vaddr, 2'd0);
            return 1'b1;
        end
        if (!walk_busy)
            return 1'b0;
        field = it.table_entry & ADDR_FIELD_MASK;
        if (!it.table_entry[ptw_pkg::PRESENT_BIT]) begin
            // missing entry ends the walk with a fault
            res.kind_res    = ptw_pkg::RES_DONE;
            res.fault       = 1'b1;
            res.fault_level = walk_lvl;
            walk_busy       = 1'b0;
            walk_lvl        = 2'd0;
        end else if (walk_lvl != ptw_pkg::LAST_LEVEL) begin
            walk_lvl      = walk_lvl + 2'd1;
            res.kind_res  = ptw_pkg::RES_READ;
            res.read_addr = field + cfg_window + entry_offset(walk_va, walk_lvl);
        end else begin
            res.kind_res  = ptw_pkg::RES_DONE;
            res.phys_addr = {it.table_entry[51:12], walk_va[11:0]};
            walk_busy     = 1'b0;
            walk_lvl      = 2'd0;
        end
        return 1'b1;
    endfunction

    function automatic ptw_pkg::t_out_item rd_res(input logic [63:0] addr);
        ptw_pkg::t_out_item r;
        r = '0;
        r.kind_res  = ptw_pkg::RES_READ;
        r.read_addr = addr;
        return r;
    endfunction

    function automatic ptw_pkg::t_out_item fin_res(input logic [ptw_pkg::PA_W-1:0] pa,
                                                   input logic f,
                                                   input logic [1:0] lvl);
        ptw_pkg::t_out_item r;
        r = '0;
        r.kind_res    = ptw_pkg::RES_DONE;
        r.phys_addr   = pa;
        r.fault       = f;
        r.fault_level = lvl;
        return r;
    endfunction

    function automatic ptw_pkg::t_in_item mk_item(input logic k,
                                                  input logic [ptw_pkg::VA_W-1:0] va,
                                                  input logic [63:0] entry);
        ptw_pkg::t_in_item it;
        it.kind        = k;
        it.vaddr       = va;
        it.table_entry = entry;
        return it;
    endfunction

    function automatic void add_row(input ptw_pkg::t_in_item it, input t_stim_check chk,
                                    input ptw_pkg::t_out_item res);
        t_stim_row row;
        row.item = it;
        row.chk  = chk;
        row.res  = res;
        dir_rows.push_back(row);
    endfunction

    // Offer one item, wait for the handshake, then log its expectation
    task automatic send_item(input ptw_pkg::t_in_item it, input t_stim_check chk,
                             input ptw_pkg::t_out_item fixed, output bit caused);
        ptw_pkg::t_out_item res;
        bit                 got;
        int                 gap;
        gap = src_burst ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 31) == 0)
            src_burst = !src_burst;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (!o_ready);
        got = walk_predict(it, res);
        case (chk)
            CHK_MODEL: if (got) pending_results.push_back(res);
            CHK_FIXED: pending_results.push_back(fixed);
            default: ;
        endcase
        caused = (chk == CHK_MODEL) ? got : (chk == CHK_FIXED);
        items_taken++;
        @(negedge i_clk);
    endtask

    // Write a register, then read it back
    task automatic apb_write_check(input logic reg_sel, input logic [63:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 3'b000};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (reg_sel == ptw_pkg::REG_ROOT)
            cfg_root = val;
        else
            cfg_window = val;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== val)
            note_error($sformatf("reg %0d readback exp %h got %h", reg_sel, val, prdata));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait until every expected result is in, then let the pipe settle
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        ptw_pkg::t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (o_item.kind_res == ptw_pkg::RES_READ)
                n_reads++;
            else if (o_item.fault)
                n_faults++;
            else
                n_done++;
            if (pending_results.size() == 0) begin
                note_error($sformatf("unexpected result kind=%0d ra=%h pa=%h f=%0d lvl=%0d",
                                     o_item.kind_res, o_item.read_addr, o_item.phys_addr,
                                     o_item.fault, o_item.fault_level));
            end else begin
                want = pending_results.pop_front();
                if (o_item !== want)
                    note_error($sformatf({"result mismatch exp kind=%0d ra=%h pa=%h f=%0d ",
                                          "lvl=%0d got kind=%0d ra=%h pa=%h f=%0d lvl=%0d"},
                                         want.kind_res, want.read_addr, want.phys_addr,
                                         want.fault, want.fault_level, o_item.kind_res,
                                         o_item.read_addr, o_item.phys_addr, o_item.fault,
                                         o_item.fault_level));
            end
        end
    end

    // Result receiver: random stalls, bursts, and one long hold-off
    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if ($urandom_range(0, 31) == 0)
                sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
            @(negedge i_clk);
        end
    end

    // Main stimulus
    initial begin
        logic [63:0]              rnd;
        logic [63:0]              root_val;
        logic [63:0]              win_val;
        logic [ptw_pkg::VA_W-1:0] va;
        ptw_pkg::t_in_item        it;
        bit                       caused;
        int                       phase_items;
        int                       roll;

        errors      = 0;
        cycle_cnt   = 0;
        items_taken = 0;
        n_reads     = 0;
        n_done      = 0;
        n_faults    = 0;
        n_settings  = 1;
        src_burst   = 1'b0;
        sink_burst  = 1'b0;
        hold_req    = 1'b0;
        walk_busy   = 1'b0;
        walk_lvl    = 2'd0;
        walk_va     = '0;
        cfg_root    = '0;
        cfg_window  = '0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_item      = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows, registers at their reset values
        add_row(mk_item(ptw_pkg::KIND_RESP, '0, '1), CHK_NONE, '0);   // response while idle
        add_row(mk_item(ptw_pkg::KIND_XLATE, '1, '0), CHK_FIXED, rd_res(64'h0FF8));
        add_row(mk_item(ptw_pkg::KIND_XLATE, '0, '0), CHK_NONE, '0);  // request while busy
        add_row(mk_item(ptw_pkg::KIND_RESP, '0, '1), CHK_FIXED,
                rd_res(64'h000F_FFFF_FFFF_FFF8));
        add_row(mk_item(ptw_pkg::KIND_RESP, '0, '1), CHK_FIXED,
                rd_res(64'h000F_FFFF_FFFF_FFF8));
        add_row(mk_item(ptw_pkg::KIND_RESP, '0, '1), CHK_FIXED,
                rd_res(64'h000F_FFFF_FFFF_FFF8));
        add_row(mk_item(ptw_pkg::KIND_RESP, '0, '1), CHK_FIXED, fin_res('1, 1'b0, 2'd0));
        add_row(mk_item(ptw_pkg::KIND_XLATE, '0, '1), CHK_FIXED, rd_res(64'h0));
        add_row(mk_item(ptw_pkg::KIND_RESP, '1, '0), CHK_FIXED, fin_res('0, 1'b1, 2'd0));
        add_row(mk_item(ptw_pkg::KIND_XLATE, 48'h1234_5678_9ABC, '0), CHK_MODEL, '0);
        add_row(mk_item(ptw_pkg::KIND_RESP, '0, 64'h8000_0000_0000_0001), CHK_MODEL, '0);
        add_row(mk_item(ptw_pkg::KIND_RESP, '0, 64'h2), CHK_FIXED, fin_res('0, 1'b1, 2'd1));
        add_row(mk_item(ptw_pkg::KIND_XLATE, 48'h7FFF_FFFF_F000, '0), CHK_MODEL, '0);
        add_row(mk_item(ptw_pkg::KIND_RESP, '0, 64'h1001), CHK_MODEL, '0);
        add_row(mk_item(ptw_pkg::KIND_RESP, '0, 64'h2081), CHK_MODEL, '0);   // huge bit set
        add_row(mk_item(ptw_pkg::KIND_RESP, '0, 64'hFFFF_FFFF_FFFF_FFFE), CHK_FIXED,
                fin_res('0, 1'b1, 2'd2));
        add_row(mk_item(ptw_pkg::KIND_XLATE, 48'h8000_0000_0FFF, '0), CHK_MODEL, '0);
        add_row(mk_item(ptw_pkg::KIND_RESP, '0, 64'h1), CHK_MODEL, '0);
        add_row(mk_item(ptw_pkg::KIND_RESP, '0, 64'h1), CHK_MODEL, '0);
        add_row(mk_item(ptw_pkg::KIND_RESP, '0, 64'h1), CHK_MODEL, '0);
        add_row(mk_item(ptw_pkg::KIND_RESP, '0, 64'h7FFF_FFFF_FFFF_FFFE), CHK_FIXED,
                fin_res('0, 1'b1, 2'd3));
        add_row(mk_item(ptw_pkg::KIND_RESP, '0, '0), CHK_NONE, '0);

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].chk, dir_rows[i].res, caused);
        drain();

        // Random phases, each under its own register setting
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin root_val = '1; win_val = '1; end   // address wrap
                1: begin root_val = '0; win_val = '0; end
                2: begin root_val = 64'hFFFF_FFFF_FFFF_F000; win_val = {$urandom, $urandom}; end
                default: begin root_val = {$urandom, $urandom}; win_val = {$urandom, $urandom}; end
            endcase
            apb_write_check(ptw_pkg::REG_ROOT, root_val);
            apb_write_check(ptw_pkg::REG_WINDOW, win_val);
            n_settings++;
            if (phase == 2)
                hold_req = 1'b1;

            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                roll = $urandom_range(0, 9);
                rnd  = {$urandom, $urandom};
                case ($urandom_range(0, 15))
                    0: va = '0;
                    1: va = '1;
                    default: va = rnd[ptw_pkg::VA_W-1:0];
                endcase
                // mostly well-formed walks, some stray items
                if (walk_busy == (roll != 0)) begin
                    rnd = {$urandom, $urandom};
                    case ($urandom_range(0, 15))
                        0: rnd = '1;
                        1: rnd = 64'h1;
                        default: rnd[ptw_pkg::PRESENT_BIT] = ($urandom_range(0, 7) != 0);
                    endcase
                    it = mk_item(ptw_pkg::KIND_RESP, va, rnd);
                end else begin
                    it = mk_item(ptw_pkg::KIND_XLATE, va, rnd);
                end
                send_item(it, CHK_MODEL, '0, caused);
                if (caused)
                    phase_items++;
            end

            // close any open walk before the registers change
            while (walk_busy) begin
                rnd = {$urandom, $urandom};
                rnd[ptw_pkg::PRESENT_BIT] = 1'b0;
                send_item(mk_item(ptw_pkg::KIND_RESP, '0, rnd), CHK_MODEL, '0, caused);
            end
            drain();
        end

        if (pending_results.size() != 0)
            note_error($sformatf("%0d expected results never arrived", pending_results.size()));

        $display("Run took %0d items over %0d register settings in %0d cycles",
                 items_taken, n_settings, cycle_cnt);
        $display("Results seen: %0d table reads, %0d translations, %0d faults, %0d errors",
                 n_reads, n_done, n_faults, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/ptw_pkg.sv
sv/ptw_front.sv
sv/ptw_job_queue.sv
sv/ptw_back.sv
sv/page_table_walk_translate.sv
verif/tb.sv
